@@ src/smme_pkg.sv @@
// ----------------------------------------------------------------------------
// smme_pkg: shared types, constants and microcode for the matrix multiplier
// Field widths, function and register codes, control word layout and the
// control program that the sequencer steps through.
// ----------------------------------------------------------------------------
package smme_pkg;

   localparam int IDX_W     = 3;   // row / col field width
   localparam int DIM_W     = 4;   // dimension register width
   localparam int VAL_W     = 16;  // Q8.8 element
   localparam int PROD_W    = 32;  // Q16.16 product
   localparam int ACC_W     = 40;  // Q24.16 accumulator / result
   localparam int FUNC_W    = 2;
   localparam int CSR_IDX_W = 2;
   localparam int PC_W      = 2;

   localparam logic [FUNC_W-1:0] FUNC_LOAD_A  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_B  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLS_B    = 2'd2;

   localparam logic [PC_W-1:0] PC_IDLE = 2'd0;
   localparam logic [PC_W-1:0] PC_MAC  = 2'd1;
   localparam logic [PC_W-1:0] PC_DONE = 2'd2;

   // branch conditions: taken -> target, else fall through to pc + 1
   typedef enum logic [1:0] {
      COND_NEVER,
      COND_NOT_GO,
      COND_NOT_END,
      COND_ALWAYS
   } cond_type;

   // datapath controls of one step
   typedef struct packed {
      logic clr;   // clear loop counters
      logic rd;    // issue operand reads at current indices
      logic adv;   // advance k, wrapping into j and i
   } ctrl_type;

   typedef struct packed {
      ctrl_type            ctrl;
      cond_type            cond;
      logic [PC_W-1:0]     target;
   } ucode_type;

   // datapath status seen by the sequencer
   typedef struct packed {
      logic run_end;    // current indices are the last of the run
      logic pipe_busy;  // reads still in flight
   } stat_type;

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '{ctrl: '{clr: 1'b0, rd: 1'b0, adv: 1'b0}, cond: COND_ALWAYS, target: PC_IDLE};
      case (pc)
         PC_IDLE: begin
            w.ctrl.clr = 1'b1;
            w.cond     = COND_NOT_GO;
            w.target   = PC_IDLE;
         end
         PC_MAC: begin
            w.ctrl.rd  = 1'b1;
            w.ctrl.adv = 1'b1;
            w.cond     = COND_NOT_END;
            w.target   = PC_MAC;
         end
         PC_DONE: begin
            w.cond   = COND_ALWAYS;
            w.target = PC_IDLE;
         end
         default: begin
            w.cond   = COND_ALWAYS;
            w.target = PC_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

@@ src/small_matrix_multiply_engine.sv @@
// Loads write the stores directly. A compute does one multiply-accumulate per
// i/j/k index triple through the single MAC pipeline and one read port per
// store; each result strobes once its last product has passed the read,
// multiply and accumulate stages. Busy falls once the sequencer is parked and
// no read is in flight. The receiver cannot stall. Synchronous reset sets all
// dimensions to MAX_DIM and idles the sequencer; stores are not cleared.
// ----------------------------------------------------------------------------
// small_matrix_multiply_engine: top level
// Loads A and B element by element and streams C = A * B in row-major order
// as exact Q24.16 sums of Q8.8 products.
// ----------------------------------------------------------------------------
module small_matrix_multiply_engine #(
   parameter int MAX_DIM = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // command channel
   input  logic                                 start,
   output logic                                 busy,
   input  logic [smme_pkg::FUNC_W-1:0]          req_func,
   input  logic [smme_pkg::IDX_W-1:0]           req_row,
   input  logic [smme_pkg::IDX_W-1:0]           req_col,
   input  logic signed [smme_pkg::VAL_W-1:0]    req_value,
   // result channel
   output logic                                 rsp_strobe,
   output logic [smme_pkg::IDX_W-1:0]           rsp_out_row,
   output logic [smme_pkg::IDX_W-1:0]           rsp_out_col,
   output logic signed [smme_pkg::ACC_W-1:0]    rsp_out_value,
   output logic                                 rsp_last,
   // register write port
   input  logic                                 csr_we,
   input  logic [smme_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [smme_pkg::DIM_W-1:0]           csr_wdata
);

   smme_pkg::ctrl_type ctrl;
   smme_pkg::stat_type stat;
   logic               seq_busy;
   logic               accept;
   logic               go;
   logic               load_a;
   logic               load_b;

   // A transfer is taken only when the sequencer is parked and no read is
   // still in flight. Loads write the stores directly; func 3 is dropped.
   always_comb begin
      busy   = seq_busy || stat.pipe_busy;
      accept = start && !busy;
      go     = accept && (req_func == smme_pkg::FUNC_COMPUTE);
      load_a = accept && (req_func == smme_pkg::FUNC_LOAD_A);
      load_b = accept && (req_func == smme_pkg::FUNC_LOAD_B);
   end

   // Control program: park and clear counters, then one read per cycle over
   // the whole i/j/k space, then return to park.
   smme_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .stat     (stat),
      .ctrl     (ctrl),
      .seq_busy (seq_busy)
   );

   // Stores, counters, 3-stage read/multiply/accumulate and result register.
   // The pipeline carries first/last flags, so sums close on their own.
   smme_dp #(
      .MAX_DIM (MAX_DIM)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .stat          (stat),
      .load_a        (load_a),
      .load_b        (load_b),
      .ld_row        (req_row),
      .ld_col        (req_col),
      .ld_value      (req_value),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last)
   );

endmodule

@@ src/smme_seq.sv @@
// ----------------------------------------------------------------------------
// smme_seq: microcode sequencer
// Step counter over the control ROM with conditional branches.
// ----------------------------------------------------------------------------
module smme_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  smme_pkg::stat_type   stat,
   output smme_pkg::ctrl_type   ctrl,
   output logic                 seq_busy
);

   logic [smme_pkg::PC_W-1:0] pc_ff;
   logic [smme_pkg::PC_W-1:0] pc_in;
   smme_pkg::ucode_type       uword;
   logic                      take;

   always_comb begin
      uword = smme_pkg::ucode_rom(pc_ff);
      ctrl  = uword.ctrl;
      case (uword.cond)
         smme_pkg::COND_NOT_GO:  take = !go;
         smme_pkg::COND_NOT_END: take = !stat.run_end;
         smme_pkg::COND_ALWAYS:  take = 1'b1;
         default:                take = 1'b0;
      endcase
      pc_in    = take ? uword.target : pc_ff + smme_pkg::PC_W'(1);
      seq_busy = (pc_ff != smme_pkg::PC_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= smme_pkg::PC_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

@@ src/smme_dp.sv @@
// ----------------------------------------------------------------------------
// smme_dp: matrix multiplier datapath
// Dimension registers, element stores, loop counters, read / multiply /
// accumulate pipeline and the result register.
// ----------------------------------------------------------------------------
module smme_dp #(
   parameter int MAX_DIM = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  smme_pkg::ctrl_type                   ctrl,
   output smme_pkg::stat_type                   stat,
   // element loads
   input  logic                                 load_a,
   input  logic                                 load_b,
   input  logic [smme_pkg::IDX_W-1:0]           ld_row,
   input  logic [smme_pkg::IDX_W-1:0]           ld_col,
   input  logic signed [smme_pkg::VAL_W-1:0]    ld_value,
   // register writes
   input  logic                                 csr_we,
   input  logic [smme_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [smme_pkg::DIM_W-1:0]           csr_wdata,
   // results
   output logic                                 rsp_strobe,
   output logic [smme_pkg::IDX_W-1:0]           rsp_out_row,
   output logic [smme_pkg::IDX_W-1:0]           rsp_out_col,
   output logic signed [smme_pkg::ACC_W-1:0]    rsp_out_value,
   output logic                                 rsp_last
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_DIM);
   localparam int DW    = smme_pkg::DIM_W;
   localparam int OW    = smme_pkg::IDX_W;
   localparam int VW    = smme_pkg::VAL_W;
   localparam int PW    = smme_pkg::PROD_W;
   localparam int SW    = smme_pkg::ACC_W;

   typedef struct packed {
      logic          first;   // k == 0: start a new sum
      logic          lastk;   // final term of this element
      logic          endr;    // final element of the run
      logic [CW-1:0] i;
      logic [CW-1:0] j;
   } tag_type;

   // dimension registers
   logic [DW-1:0] rows_a_ff, inner_ff, cols_b_ff;
   logic [DW-1:0] dim_in;

   // stores
   logic [VW-1:0] mem_a [DEPTH];
   logic [VW-1:0] mem_b [DEPTH];
   logic          ld_ok;
   logic [AW-1:0] wr_addr, rd_a_addr, rd_b_addr;

   // loop counters
   logic [CW-1:0] i_ff, j_ff, k_ff;
   logic [CW-1:0] i_in, j_in, k_in;
   logic          i_last, j_last, k_last;

   // pipeline
   logic                 s1_v_ff, s2_v_ff;
   tag_type              s1_tag_ff, s2_tag_ff, tag_in;
   logic signed [VW-1:0] a_rd_ff, b_rd_ff;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [SW-1:0] acc_ff, acc_in;

   // result register
   logic                 rsp_strobe_ff;
   logic [OW-1:0]        rsp_row_ff, rsp_col_ff;
   logic signed [SW-1:0] rsp_value_ff;
   logic                 rsp_last_ff;

   // saturate a written dimension into 1..MAX_DIM
   always_comb begin
      if (csr_wdata == '0) begin
         dim_in = DW'(1);
      end else if (csr_wdata > DW'(MAX_DIM)) begin
         dim_in = DW'(MAX_DIM);
      end else begin
         dim_in = csr_wdata;
      end
   end

   // reset value MAX_DIM; writes store the saturated dimension
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= DW'(MAX_DIM);
         inner_ff  <= DW'(MAX_DIM);
         cols_b_ff <= DW'(MAX_DIM);
      end else if (csr_we) begin
         case (csr_index)
            smme_pkg::REG_ROWS_A:    rows_a_ff <= dim_in;
            smme_pkg::REG_INNER_DIM: inner_ff  <= dim_in;
            smme_pkg::REG_COLS_B:    cols_b_ff <= dim_in;
            default: begin
            end
         endcase
      end
   end

   // addresses: row * MAX_DIM + col
   always_comb begin
      ld_ok     = (DW'(ld_row) < DW'(MAX_DIM)) && (DW'(ld_col) < DW'(MAX_DIM));
      wr_addr   = AW'(ld_row) * AW'(MAX_DIM) + AW'(ld_col);
      rd_a_addr = AW'(i_ff) * AW'(MAX_DIM) + AW'(k_ff);
      rd_b_addr = AW'(k_ff) * AW'(MAX_DIM) + AW'(j_ff);
   end

   always_ff @(posedge clock) begin
      if (load_a && ld_ok) begin
         mem_a[wr_addr] <= ld_value;
      end
      if (ctrl.rd) begin
         a_rd_ff <= mem_a[rd_a_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (load_b && ld_ok) begin
         mem_b[wr_addr] <= ld_value;
      end
      if (ctrl.rd) begin
         b_rd_ff <= mem_b[rd_b_addr];
      end
   end

   // nested loop counters, k innermost
   always_comb begin
      i_last = (DW'(i_ff) == rows_a_ff - DW'(1));
      j_last = (DW'(j_ff) == cols_b_ff - DW'(1));
      k_last = (DW'(k_ff) == inner_ff - DW'(1));
      i_in   = i_ff;
      j_in   = j_ff;
      k_in   = k_ff;
      if (ctrl.clr) begin
         i_in = '0;
         j_in = '0;
         k_in = '0;
      end else if (ctrl.adv) begin
         if (k_last) begin
            k_in = '0;
            if (j_last) begin
               j_in = '0;
               i_in = i_ff + CW'(1);
            end else begin
               j_in = j_ff + CW'(1);
            end
         end else begin
            k_in = k_ff + CW'(1);
         end
      end
      tag_in = '{first: (k_ff == '0), lastk: k_last, endr: i_last && j_last && k_last,
                 i: i_ff, j: j_ff};
      stat.run_end   = i_last && j_last && k_last;
      stat.pipe_busy = s1_v_ff || s2_v_ff;
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;
      j_ff <= j_in;
      k_ff <= k_in;
   end

   // multiply and accumulate
   always_comb begin
      prod_in = a_rd_ff * b_rd_ff;
      acc_in  = (s2_tag_ff.first ? '0 : acc_ff) + SW'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff       <= 1'b0;
         s2_v_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         s1_v_ff       <= ctrl.rd;
         s2_v_ff       <= s1_v_ff;
         rsp_strobe_ff <= s2_v_ff && s2_tag_ff.lastk;
      end
      s1_tag_ff <= tag_in;
      s2_tag_ff <= s1_tag_ff;
      prod_ff   <= prod_in;
      if (s2_v_ff) begin
         acc_ff <= acc_in;
      end
      rsp_row_ff   <= OW'(s2_tag_ff.i);
      rsp_col_ff   <= OW'(s2_tag_ff.j);
      rsp_value_ff <= acc_in;
      rsp_last_ff  <= s2_tag_ff.endr;
   end

   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_last      = rsp_last_ff;

endmodule
